// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker; clock and reset are i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

    localparam int FRAMES    = 64;
    localparam int IDX_W     = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int OUT_IDX_W = 6;
    localparam int CFG_W     = 7;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [CFG_W-1:0] FRAMES_USED_RESET = CFG_W'(64);
    localparam logic             REG_FRAMES_USED   = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             best;
        logic [IDX_W-1:0] best_idx;
        logic [31:0]      best_uses;
        logic [31:0]      best_time;
    } t_scan;

    typedef struct packed {
        logic             shift;
        logic             wr_en;
        logic             wr_hit;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      wr_page;
        logic [31:0]      wr_time;
    } t_ctl;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

// ===== sv/lfu_page_replacement_core.sv =====
// The idle state takes the beat, the scan wave walks the cell chain one frame per cycle,
// then the commit state writes the frame. o_stall is high while a beat is scanned or
// committed, so a new access waits until the previous one has committed.
// The next access is taken while a finished result still waits downstream; its commit
// holds while that result stays stalled.
// Reset (synchronous, active low): all frames invalid, clock and hit total zero.
module lfu_page_replacement_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_page_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic        o_evicted,
    output logic [5:0]  o_frame_index,
    output logic [31:0] o_hit_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lfu_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_cnt;
    logic [31:0]           r_page;
    logic [31:0]           r_clock;
    logic [31:0]           r_hits;
    logic [CFG_W-1:0]      r_frames_used;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic                  r_out_evicted;
    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic [31:0]           r_out_total;

    logic [CNT_W-1:0]      active;
    t_ctl                  ctl;
    t_scan                 scan [FRAMES];
    t_scan                 res;
    logic                  commit;
    logic                  accept;
    logic                  taken;
    logic [IDX_W-1:0]      sel;
    logic [IDX_W+OUT_IDX_W-1:0] sel_ext;
    logic [31:0]           n_hits;

    always_comb begin
        if (r_frames_used == '0) begin
            active = CNT_W'(1);
        end else if (32'(r_frames_used) > 32'(FRAMES)) begin
            active = CNT_W'(FRAMES);
        end else begin
            active = CNT_W'(r_frames_used);
        end
    end

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++) begin : g_cell
            t_scan scan_in;
            if (g == 0) begin : g_head
                assign scan_in = '0;
            end else begin : g_link
                assign scan_in = scan[g-1];
            end
            lfu_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_idx    (IDX_W'(g)),
                .i_active (active),
                .i_page   (r_page),
                .i_ctl    (ctl),
                .i_scan   (scan_in),
                .o_scan   (scan[g])
            );
        end
    endgenerate

    assign res     = scan[FRAMES-1];
    assign accept  = i_valid && !o_stall;
    assign taken   = r_out_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IDX_W'(FRAMES - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!(r_out_valid && i_stall)) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (res.hit) begin
            sel = res.hit_idx;
        end else if (res.free) begin
            sel = res.free_idx;
        end else begin
            sel = res.best_idx;
        end
        sel_ext     = {{OUT_IDX_W{1'b0}}, sel};
        n_hits      = res.hit ? sat_inc(r_hits) : r_hits;
        ctl.shift   = (r_state == S_SCAN);
        ctl.wr_en   = commit;
        ctl.wr_hit  = res.hit;
        ctl.wr_idx  = sel;
        ctl.wr_page = r_page;
        ctl.wr_time = r_clock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clock       <= '0;
            r_hits        <= '0;
            r_out_valid   <= 1'b0;
            r_frames_used <= FRAMES_USED_RESET;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_clock     <= sat_inc(r_clock);
                r_hits      <= n_hits;
                r_out_valid <= 1'b1;
            end else if (taken) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_USED)) begin
                r_frames_used <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page_id;
            r_cnt  <= '0;
        end else if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
        if (commit) begin
            r_out_hit     <= res.hit;
            r_out_evicted <= !res.hit && !res.free;
            r_out_idx     <= sel_ext[OUT_IDX_W-1:0];
            r_out_total   <= n_hits;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_evicted     = r_out_evicted;
    assign o_frame_index = r_out_idx;
    assign o_hit_total   = r_out_total;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_FRAMES_USED) ?
                           {{(32 - CFG_W){1'b0}}, r_frames_used} : 32'd0;

endmodule

// ===== sv/lfu_cell.sv =====
module lfu_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lfu_pkg::IDX_W-1:0] i_idx,
    input  logic [lfu_pkg::CNT_W-1:0] i_active,
    input  logic [31:0]               i_page,
    input  lfu_pkg::t_ctl             i_ctl,
    input  lfu_pkg::t_scan            i_scan,
    output lfu_pkg::t_scan            o_scan
);
    import lfu_pkg::*;

    logic        r_valid;
    logic [31:0] r_tag;
    logic [31:0] r_uses;
    logic [31:0] r_time;
    t_scan       r_scan;
    t_scan       n_scan;
    logic        act;
    logic        better;

    always_comb begin
        act    = CNT_W'(i_idx) < i_active;
        better = !i_scan.best || (r_uses < i_scan.best_uses) ||
                 ((r_uses == i_scan.best_uses) && (r_time < i_scan.best_time));
        n_scan = i_scan;
        if (act && r_valid && (r_tag == i_page) && !i_scan.hit) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = i_idx;
        end
        if (act && !r_valid && !i_scan.free) begin
            n_scan.free     = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (act && r_valid && better) begin
            n_scan.best      = 1'b1;
            n_scan.best_idx  = i_idx;
            n_scan.best_uses = r_uses;
            n_scan.best_time = r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr_en && (i_ctl.wr_idx == i_idx) && !i_ctl.wr_hit) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_idx == i_idx)) begin
            if (i_ctl.wr_hit) begin
                r_uses <= sat_inc(r_uses);
            end else begin
                r_tag  <= i_ctl.wr_page;
                r_uses <= 32'd1;
                r_time <= i_ctl.wr_time;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== sv/lfu_chk.sv =====
module lfu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_hit,
    input logic        o_evicted,
    input logic [31:0] o_hit_total
);
`include "assert_macros.svh"

    `CHK_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "result beat dropped while stalled")
    `CHK_ASSERT(a_busy_after_accept, i_valid && !o_stall |=> o_stall, "no stall after input beat")
    `CHK_ASSERT(a_hit_not_evict, o_valid |-> !(o_hit && o_evicted), "hit and eviction together")
    `CHK_ASSERT(a_hit_total, o_valid && o_hit |-> o_hit_total != 32'd0, "hit with zero total")
    `CHK_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

endmodule

bind lfu_page_replacement_core lfu_chk u_lfu_chk (.*);

// ===== test/tb_lfu_page_replacement_core.sv =====
`timescale 1ns / 1ps

module tb_lfu_page_replacement_core;
    import lfu_pkg::*;

    localparam logic [2:0] CFG_ADDR = 3'(4 * int'(REG_FRAMES_USED));
    localparam int POOL_SIZE  = 128;
    localparam int RAND_ITEMS = 650;
    localparam int PHASES     = 12;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [5:0]  frame;
        logic [31:0] total;
    } t_access_result;

    typedef enum logic [1:0] {
        ROW_ACCESS,
        ROW_CHECKED,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [31:0]    data;
        t_access_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_page_id = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_hit;
    logic        o_evicted;
    logic [5:0]  o_frame_index;
    logic [31:0] o_hit_total;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lfu_page_replacement_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_page_id     (i_page_id),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_evicted     (o_evicted),
        .o_frame_index (o_frame_index),
        .o_hit_total   (o_hit_total),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0] slot_page  [FRAMES];
    logic [31:0] slot_uses  [FRAMES];
    logic [31:0] slot_stamp [FRAMES];
    logic        slot_live  [FRAMES];
    logic [31:0] now_tick = '0;
    logic [31:0] hit_tally = '0;
    logic [6:0]  active_cfg = FRAMES_USED_RESET;

    t_access_result pending_results[$];
    logic [31:0]    page_pool[POOL_SIZE];
    logic [31:0]    last_page = '0;
    int             mismatches = 0;
    int             result_no = 0;
    int             send_idle_pct = 10;
    int             recv_idle_pct = 75;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_access_result lookup_page(input logic [31:0] page);
        t_access_result res;
        int n;
        int k;
        int sel;
        bit found;
        res = '0;
        sel = 0;
        found = 1'b0;
        n = (active_cfg == 0) ? 1 : (int'(active_cfg) > FRAMES) ? FRAMES : int'(active_cfg);
        for (k = 0; k < n && !found; k++) begin
            if (slot_live[k] && slot_page[k] == page) begin
                sel = k;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (slot_uses[sel] != '1) slot_uses[sel]++;
            if (hit_tally != '1) hit_tally++;
        end else begin
            for (k = 0; k < n && !found; k++) begin
                if (!slot_live[k]) begin
                    sel = k;
                    found = 1'b1;
                end
            end
            if (!found) begin
                sel = 0;
                for (k = 1; k < n; k++) begin
                    if (slot_uses[k] < slot_uses[sel] ||
                        (slot_uses[k] == slot_uses[sel] && slot_stamp[k] < slot_stamp[sel]))
                        sel = k;
                end
                res.evicted = 1'b1;
            end
            slot_live[sel]  = 1'b1;
            slot_page[sel]  = page;
            slot_uses[sel]  = 32'd1;
            slot_stamp[sel] = now_tick;
        end
        if (now_tick != '1) now_tick++;
        res.frame = 6'(sel);
        res.total = hit_tally;
        return res;
    endfunction

    task automatic send_page(input logic [31:0] page, input bit typed,
                             input t_access_result typed_result);
        t_access_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_page_id <= page;
        do @(posedge i_clk); while (o_stall);
        predicted = lookup_page(page);
        pending_results.push_back(typed ? typed_result : predicted);
        last_page = page;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_frames_used(input logic [6:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR;
        pwdata  <= {25'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[6:0] !== value)
            report_mismatch($sformatf("frames_used read %0d, wrote %0d", prdata[6:0], value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        active_cfg = value;
    endtask

    function automatic logic [31:0] pick_page(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return page_pool[$urandom_range(0, span - 1)];
        if (r < 80) return last_page;
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h0000_0001;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= i_rst_n ? ($urandom_range(0, 99) < recv_idle_pct) : 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_access_result got;
        t_access_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_hit, o_evicted, o_frame_index, o_hit_total};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b, want %b",
                                              result_no, got.hit, want.hit));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("result %0d evicted %b, want %b",
                                              result_no, got.evicted, want.evicted));
                if (got.frame !== want.frame)
                    report_mismatch($sformatf("result %0d frame_index %0d, want %0d",
                                              result_no, got.frame, want.frame));
                if (got.total !== want.total)
                    report_mismatch($sformatf("result %0d hit_total %0d, want %0d",
                                              result_no, got.total, want.total));
            end
            result_no++;
        end
    end

    initial begin
        #2_000_000;
        $display("** lfu_page_replacement_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_row directed_rows[23];
        int   phase_cfg[PHASES];
        int   phase_len[PHASES];
        int   item_no;
        int   eff;
        int   span;
        int   p;
        int   j;

        directed_rows = '{
            '{ROW_CHECKED, 32'h0000_0000, '{1'b0, 1'b0, 6'd0, 32'd0}},
            '{ROW_CHECKED, 32'hFFFF_FFFF, '{1'b0, 1'b0, 6'd1, 32'd0}},
            '{ROW_CHECKED, 32'h0000_0000, '{1'b1, 1'b0, 6'd0, 32'd1}},
            '{ROW_CHECKED, 32'hFFFF_FFFF, '{1'b1, 1'b0, 6'd1, 32'd2}},
            '{ROW_CHECKED, 32'h0000_0001, '{1'b0, 1'b0, 6'd2, 32'd2}},
            '{ROW_CONFIG,  32'd2,         '0},
            '{ROW_CHECKED, 32'h0000_0005, '{1'b0, 1'b1, 6'd0, 32'd2}},
            '{ROW_CHECKED, 32'h0000_0006, '{1'b0, 1'b1, 6'd0, 32'd2}},
            '{ROW_CHECKED, 32'hFFFF_FFFF, '{1'b1, 1'b0, 6'd1, 32'd3}},
            '{ROW_CONFIG,  32'd0,         '0},
            '{ROW_CHECKED, 32'h0000_0001, '{1'b0, 1'b1, 6'd0, 32'd3}},
            '{ROW_CONFIG,  32'd64,        '0},
            '{ROW_CHECKED, 32'h0000_0001, '{1'b1, 1'b0, 6'd0, 32'd4}},
            '{ROW_CHECKED, 32'h0000_0002, '{1'b0, 1'b0, 6'd3, 32'd4}},
            '{ROW_CONFIG,  32'd127,       '0},
            '{ROW_CHECKED, 32'h0000_0003, '{1'b0, 1'b0, 6'd4, 32'd4}},
            '{ROW_CONFIG,  32'd1,         '0},
            '{ROW_CHECKED, 32'h8000_0000, '{1'b0, 1'b1, 6'd0, 32'd4}},
            '{ROW_CHECKED, 32'h8000_0000, '{1'b1, 1'b0, 6'd0, 32'd5}},
            '{ROW_CHECKED, 32'hFFFF_FFFF, '{1'b0, 1'b1, 6'd0, 32'd5}},
            '{ROW_ACCESS,  32'h7FFF_FFFF, '0},
            '{ROW_ACCESS,  32'hAAAA_AAAA, '0},
            '{ROW_ACCESS,  32'h5555_5555, '0}
        };
        phase_cfg = '{64, 1, 2, 5, 0, 16, 127, 3, 64, 33, 100, 8};
        phase_len = '{90, 40, 40, 50, 30, 60, 90, 40, 60, 60, 50, 40};

        for (j = 0; j < FRAMES; j++) slot_live[j] = 1'b0;
        for (j = 0; j < POOL_SIZE; j++) page_pool[j] = $urandom;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CONFIG: begin
                    write_frames_used(directed_rows[r].data[6:0]);
                end
                ROW_CHECKED: begin
                    send_page(directed_rows[r].data, 1'b1, directed_rows[r].want);
                end
                default: begin
                    send_page(directed_rows[r].data, 1'b0, '0);
                end
            endcase
        end

        item_no = 0;
        for (p = 0; p < PHASES; p++) begin
            write_frames_used(7'(phase_cfg[p]));
            eff  = (phase_cfg[p] == 0) ? 1 : (phase_cfg[p] > FRAMES) ? FRAMES : phase_cfg[p];
            span = (2 * eff > POOL_SIZE) ? POOL_SIZE : (2 * eff < 2) ? 2 : 2 * eff;
            for (j = 0; j < phase_len[p]; j++) begin
                if (item_no < RAND_ITEMS / 3) begin
                    send_idle_pct = 10;
                    recv_idle_pct = 75;
                end else if (item_no < 2 * RAND_ITEMS / 3) begin
                    send_idle_pct = 75;
                    recv_idle_pct = 10;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if ($urandom_range(0, 49) == 0) drain_results();
                send_page(pick_page(span), 1'b0, '0);
                item_no++;
            end
        end

        drain_results();
        repeat (70) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** lfu_page_replacement_core: PASSED **");
        end else begin
            $display("** lfu_page_replacement_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_cell.sv
sv/lfu_page_replacement_core.sv
sv/lfu_chk.sv
test/tb_lfu_page_replacement_core.sv
